### src/sint2dec_pkg.sv
package sint2dec_pkg;

  localparam int DIGIT_SLOTS_DEF = 10;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // ceil(2^35 / 10): quotient by ten is (x * RECIP_10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic        negative;
    logic [31:0] magnitude;
  } sint2dec_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sint2dec_qstat_t;

endpackage

### src/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
//
// Input channel: in_valid / in_stall carry one signed value per beat on
// in_value. Output channel: out_valid / out_stall carry one character per
// beat on out_char_code, with out_last_char set on the final character.
// A negative value starts with '-'; digits follow most significant first,
// with no leading zeros; zero gives a single '0'.
//
// Values enter a two-entry queue, so up to two numbers are taken while an
// earlier one is still being written out. The back end splits one digit a
// cycle with a reciprocal multiply by ten, then emits one character a
// cycle while the output is not stalled. It writes the '-' first for a
// negative value, then the digits, and takes the next number from the
// queue only after the last character of the current one is registered.
//
// Reset empties the queue and the output register and returns the back end
// to idle. A stall on the output holds the current character; the back end
// and then the queue fill up, and in_stall rises when the queue is full.
module signed_int_to_decimal_ascii
  import sint2dec_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char_code,
  output logic               out_last_char
);

  sint2dec_qstat_t q_stat;
  sint2dec_item_t  q_item;
  sint2dec_item_t  q_head;
  logic            q_push;
  logic            q_pop;

  sint2dec_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  sint2dec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head_item (q_head),
    .stat      (q_stat)
  );

  sint2dec_back #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == ASCII_MINUS) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  // only the minus sign or a decimal digit is ever emitted
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == ASCII_MINUS) ||
                  ((out_char_code >= ASCII_ZERO) && (out_char_code <= ASCII_ZERO + 8'd9)))
    else $error("character outside sign and digits");

  // characters of one number follow without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_char |=> out_valid)
    else $error("gap inside a number's text");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

### src/sint2dec_front.sv
module sint2dec_front
  import sint2dec_pkg::*;
(
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_value,
  input  sint2dec_qstat_t       q_stat,
  output logic                  q_push,
  output sint2dec_item_t        q_item
);

  logic [31:0] raw;

  assign raw      = in_value;
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // unsigned negate: the most negative value keeps its true magnitude
  assign q_item.negative  = raw[31];
  assign q_item.magnitude = raw[31] ? (32'd0 - raw) : raw;

endmodule

### src/sint2dec_queue.sv
module sint2dec_queue
  import sint2dec_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sint2dec_item_t  push_item,
  input  logic            pop,
  output sint2dec_item_t  head_item,
  output sint2dec_qstat_t stat
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sint2dec_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/sint2dec_back.sv
module sint2dec_back
  import sint2dec_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sint2dec_qstat_t q_stat,
  input  sint2dec_item_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_char_code,
  output logic            out_last_char
);

  localparam int IDX_W = $clog2(DIGIT_SLOTS);
  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic [3:0]       digit_r [DIGIT_SLOTS];

  logic [63:0]      prod;
  logic [31:0]      quot;
  logic [31:0]      quot_x10;
  logic [3:0]       rem;
  logic             split_done;
  logic             digit_wr;
  logic             out_free;

  assign prod     = 64'(mag_r) * 64'(RECIP_10);
  assign quot     = 32'(prod >> RECIP_SHIFT);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = 4'(mag_r - quot_x10);

  // a zero magnitude still yields one digit on the first pass
  assign split_done = ((mag_r == '0) && (count_r != '0)) ||
                      (count_r == CNT_W'(DIGIT_SLOTS));
  assign out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    digit_wr      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          mag_nxt   = q_head.magnitude;
          neg_nxt   = q_head.negative;
          count_nxt = '0;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (split_done) begin
          mag_nxt   = '0;
          slot_nxt  = IDX_W'(count_r - 1'b1);
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end else begin
          digit_wr  = 1'b1;
          mag_nxt   = quot;
          count_nxt = count_r + 1'b1;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {4'd0, digit_r[slot_r]};
          out_last_nxt  = (slot_r == '0);
          if (slot_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt = slot_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      count_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (digit_wr) begin
      digit_r[IDX_W'(count_r)] <= rem;
    end
  end

endmodule

### bench/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;
  import sint2dec_pkg::*;

  localparam int RANDOM_VALUES = 248;
  localparam int SETTLE_CYCLES = 60;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_e;

  typedef struct {
    logic [7:0]         code;
    logic               last;
    logic signed [31:0] src_value;
  } char_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_char_code;
  logic               out_last_char;

  logic signed [31:0] pending_values[$];
  char_beat_t         expected_chars[$];
  int                 accepted_count = 0;
  int                 error_count = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_phase_left = 0;
  logic [31:0] stall_mask = '0;

  signed_int_to_decimal_ascii #(
    .DIGIT_SLOTS(DIGIT_SLOTS_DEF)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Split the magnitude into decimal digits and queue the characters of its text.
  task automatic predict_text(input logic signed [31:0] value);
    logic        negative;
    logic [31:0] magnitude;
    logic [3:0]  digits[DIGIT_SLOTS_DEF];
    int          count;
    char_beat_t  beat;
    negative = value[31];
    magnitude = negative ? (32'd0 - value) : value;
    count = 0;
    if (magnitude == 32'd0) begin
      digits[0] = 4'd0;
      count = 1;
    end
    while (magnitude != 32'd0 && count < DIGIT_SLOTS_DEF) begin
      digits[count] = 4'(magnitude % 32'd10);
      magnitude = magnitude / 32'd10;
      count++;
    end
    beat.src_value = value;
    if (negative) begin
      beat.code = ASCII_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int slot = count - 1; slot >= 0; slot--) begin
      beat.code = ASCII_ZERO + {4'd0, digits[slot]};
      beat.last = (slot == 0);
      expected_chars.push_back(beat);
    end
  endtask

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_values.size() != 0) begin
        in_value <= pending_values.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: picks a new random stall mode each time its phase runs out.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_phase_left = $urandom_range(20, 90);
        stall_mask = $urandom;
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= stall_mask[0];
          stall_mask = {stall_mask[0], stall_mask[31:1]};
        end
      endcase
    end
  end

  // Capture accepted values first, then check the character beat of this edge.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_text(in_value);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%b",
                                    out_char_code, out_last_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code) begin
            report_mismatch($sformatf("value %0d: char 0x%02h, want 0x%02h",
                                      want.src_value, out_char_code, want.code));
          end
          if (out_last_char !== want.last) begin
            report_mismatch($sformatf("value %0d: last_char %b, want %b",
                                      want.src_value, out_last_char, want.last));
          end
        end
      end
    end
  end

  initial begin
    logic signed [31:0] directed_values[];
    longint magnitude;
    longint lo;
    longint hi;
    logic   negative;
    int     total;
    directed_values = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      -32'sd5, 32'sd1000, 32'sd123456789, 32'sd999999999, -32'sd999999999,
      32'sd1000000000, 32'sd1999999999, 32'sd2147483647, 32'h8000_0000,
      32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd1000000001, -32'sd1000000000
    };
    foreach (directed_values[i]) pending_values.push_back(directed_values[i]);
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      negative = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: begin
          pending_values.push_back($urandom);
        end
        1: begin
          // land right at a power of ten, or one off it
          lo = 1;
          repeat ($urandom_range(0, 9)) lo = lo * 10;
          magnitude = lo + $urandom_range(0, 2) - 1;
          pending_values.push_back(negative ? 32'(-magnitude) : 32'(magnitude));
        end
        default: begin
          // pick a digit count first so short and long texts are equally common
          lo = 1;
          repeat ($urandom_range(0, 9)) lo = lo * 10;
          hi = lo * 10 - 1;
          if (lo == 1) lo = 0;
          if (hi > 64'sd2147483647) hi = negative ? 64'sd2147483648 : 64'sd2147483647;
          magnitude = lo + longint'($urandom) % (hi - lo + 1);
          pending_values.push_back(negative ? 32'(-magnitude) : 32'(magnitude));
        end
      endcase
    end
    total = pending_values.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    end
    if (error_count == 0) begin
      $display("signed_int_to_decimal_ascii verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("signed_int_to_decimal_ascii verification failed");
    $finish;
  end

endmodule
